// ----- src/sacl_pkg.sv -----
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the cache tag and policy engine
// Transfer payloads, register indexes, default geometry and a log helper.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int SETS_DEF         = 64;
  localparam int WAYS_DEF         = 4;
  localparam int BLOCK_BYTES_DEF  = 64;
  localparam int ADDRESS_BITS_DEF = 32;

  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WR_THRU  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WR_ALLOC = 8'd1;

  typedef struct packed {
    logic              operation;   // 0 read, 1 write
    logic [ADDR_W-1:0] address;
  } sacl_req_t;

  typedef struct packed {
    logic              hit;
    logic [1:0]        way;
    logic              writeback_valid;
    logic [ADDR_W-1:0] writeback_address;
    logic              lower_valid;
    logic [ADDR_W-1:0] lower_address;
    logic              lower_is_write;
  } sacl_res_t;

  typedef struct packed {
    logic wr_thru;
    logic wr_alloc;
  } sacl_mode_t;

  // floor of log2, evaluated at elaboration
  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

// ----- src/sacl_if.sv -----
// ----------------------------------------------------------------------------
// sacl_if: channel interfaces of the cache tag and policy engine
// Access request, lookup result and configuration write channels.
// ----------------------------------------------------------------------------
interface sacl_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [sacl_pkg::ADDR_W-1:0] address;

  modport source (output valid, output operation, output address, input ready);
  modport sink   (input valid, input operation, input address, output ready);
endinterface

interface sacl_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [1:0]                  way;
  logic                        writeback_valid;
  logic [sacl_pkg::ADDR_W-1:0] writeback_address;
  logic                        lower_valid;
  logic [sacl_pkg::ADDR_W-1:0] lower_address;
  logic                        lower_is_write;

  modport source (output valid, output hit, output way, output writeback_valid,
                  output writeback_address, output lower_valid, output lower_address,
                  output lower_is_write, input ready);
  modport sink   (input valid, input hit, input way, input writeback_valid,
                  input writeback_address, input lower_valid, input lower_address,
                  input lower_is_write, output ready);
endinterface

interface sacl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sacl_pkg::CFG_IDX_W-1:0]  index;
  logic [sacl_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/sacl_tag_store.sv -----
// ----------------------------------------------------------------------------
// sacl_tag_store: per-set line state
// Tag/dirty/rank memory, one row per set, plus valid flops cleared by reset.
// Read data is registered; a row written in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module sacl_tag_store #(
  parameter int SETS   = sacl_pkg::SETS_DEF,
  parameter int WAYS   = sacl_pkg::WAYS_DEF,
  parameter int ENT_W  = 24,
  parameter int SIDX_W = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [SIDX_W-1:0]          rd_set,
  output logic [WAYS-1:0][ENT_W-1:0] rd_row,
  output logic [WAYS-1:0]            rd_valid,
  input  logic                       wr_en,
  input  logic [SIDX_W-1:0]          wr_set,
  input  logic [WAYS-1:0][ENT_W-1:0] wr_row,
  input  logic [WAYS-1:0]            wr_valid
);

  logic [WAYS-1:0][ENT_W-1:0] mem [SETS];
  logic [WAYS-1:0]            valid_r [SETS];
  logic [WAYS-1:0][ENT_W-1:0] rd_row_r;
  logic [WAYS-1:0]            rd_valid_r;
  logic                       fwd;

  assign fwd = wr_en && (wr_set == rd_set);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= fwd ? wr_row : mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SETS; i++) begin
        valid_r[i] <= '0;
      end
    end else if (wr_en) begin
      valid_r[wr_set] <= wr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid_r <= fwd ? wr_valid : valid_r[rd_set];
    end
  end

  assign rd_row   = rd_row_r;
  assign rd_valid = rd_valid_r;

endmodule

// ----- src/sacl_policy.sv -----
// ----------------------------------------------------------------------------
// sacl_policy: hit check, victim choice, LRU ageing and write policy
// Purely combinational; works on one set row and produces the updated row.
// ----------------------------------------------------------------------------
module sacl_policy #(
  parameter int WAYS   = sacl_pkg::WAYS_DEF,
  parameter int TAG_W  = 20,
  parameter int SIDX_W = 6,
  parameter int OFF_W  = 6,
  parameter int SET_W  = 6
) (
  input  sacl_pkg::sacl_req_t                                   req,   // address already masked
  input  logic [SIDX_W-1:0]                                     set_idx,
  input  logic [TAG_W-1:0]                                      tag,
  input  sacl_pkg::sacl_mode_t                                  mode,
  input  logic [WAYS-1:0][TAG_W+((WAYS>1)?$clog2(WAYS):1):0]    row,
  input  logic [WAYS-1:0]                                       vld,
  output logic [WAYS-1:0][TAG_W+((WAYS>1)?$clog2(WAYS):1):0]    new_row,
  output logic [WAYS-1:0]                                       new_vld,
  output sacl_pkg::sacl_res_t                                   res
);

  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int ENT_W  = TAG_W + 1 + RANK_W;
  localparam int OLD_W  = $clog2(WAYS + 1);
  localparam int SH     = OFF_W + SET_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);
  localparam logic [OLD_W-1:0]  RANK_NONE = OLD_W'(WAYS);
  localparam logic [sacl_pkg::ADDR_W-1:0] BLOCK_ALIGN =
    ~((sacl_pkg::ADDR_W'(1) << OFF_W) - sacl_pkg::ADDR_W'(1));

  logic              hit_any, inv_any, alloc, fwd_only, vic_dirty;
  logic [WAY_W-1:0]  hit_w, inv_w, lru_w, w;
  logic [RANK_W-1:0] best, rank_i;
  logic [OLD_W-1:0]  old_rank;
  logic [TAG_W-1:0]  w_tag;
  logic [RANK_W-1:0] w_rank;
  logic              w_dirty;

  // way search
  always_comb begin
    hit_any = 1'b0;
    hit_w   = '0;
    inv_any = 1'b0;
    inv_w   = '0;
    best    = '0;
    lru_w   = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (vld[i] && (row[i][ENT_W-1 -: TAG_W] == tag)) begin
        hit_any = 1'b1;
        hit_w   = WAY_W'(i);
      end
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (!vld[i]) begin
        inv_any = 1'b1;
        inv_w   = WAY_W'(i);
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (row[i][RANK_W-1:0] > best) begin
        best  = row[i][RANK_W-1:0];
        lru_w = WAY_W'(i);
      end
    end
  end

  assign fwd_only = !hit_any && req.operation && !mode.wr_alloc;
  assign alloc    = !hit_any && !fwd_only;

  always_comb begin
    priority if (hit_any) begin
      w = hit_w;
    end else if (alloc && inv_any) begin
      w = inv_w;
    end else if (alloc) begin
      w = lru_w;
    end else begin
      w = '0;
    end
  end

  assign w_tag     = row[w][ENT_W-1 -: TAG_W];
  assign w_dirty   = row[w][RANK_W];
  assign w_rank    = row[w][RANK_W-1:0];
  assign vic_dirty = vld[w] && w_dirty;
  assign old_rank  = vld[w] ? OLD_W'(w_rank) : RANK_NONE;

  // state update: age the more recent lines, make way w rank 0
  always_comb begin
    new_row = row;
    new_vld = vld;
    rank_i  = '0;
    if (hit_any || alloc) begin
      for (int i = 0; i < WAYS; i++) begin
        rank_i = row[i][RANK_W-1:0];
        if ((WAY_W'(i) != w) && vld[i] && (OLD_W'(rank_i) < old_rank) &&
            (rank_i < RANK_MAX)) begin
          new_row[i][RANK_W-1:0] = rank_i + RANK_W'(1);
        end
      end
      if (hit_any) begin
        new_row[w] = {w_tag, w_dirty | (req.operation & ~mode.wr_thru), {RANK_W{1'b0}}};
      end else begin
        new_row[w] = {tag, req.operation, {RANK_W{1'b0}}};
        new_vld[w] = 1'b1;
      end
    end
  end

  // result
  always_comb begin
    res                   = '0;
    res.hit               = hit_any;
    res.way               = 2'(w);
    if (hit_any) begin
      if (req.operation && mode.wr_thru) begin
        res.lower_valid    = 1'b1;
        res.lower_address  = req.address;
        res.lower_is_write = 1'b1;
      end
    end else if (fwd_only) begin
      res.lower_valid    = 1'b1;
      res.lower_address  = req.address;
      res.lower_is_write = 1'b1;
    end else begin
      if (vic_dirty) begin
        res.writeback_valid   = 1'b1;
        res.writeback_address = (sacl_pkg::ADDR_W'(w_tag) << SH) |
                                (sacl_pkg::ADDR_W'(set_idx) << OFF_W);
      end
      res.lower_valid    = 1'b1;
      res.lower_address  = req.address & BLOCK_ALIGN;
      res.lower_is_write = 1'b0;
    end
  end

endmodule

// ----- src/set_assoc_cache_lru_controller.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_controller: set-associative cache tag and policy engine
// LRU replacement, write-back or write-through, optional write-allocate.
// ----------------------------------------------------------------------------
// One access is taken per clock while results can drain, and every access
// gives exactly one result. At the transfer edge the set's row (tags, dirty
// bits, LRU ranks, valid bits) is read from the tag store into a register;
// while the access is held in the lookup stage all ways are compared and the
// victim, the LRU ages and the lower-level requests are worked out, and the
// result lands in the output register once it is free while the updated row
// is written back. Sustained rate is one access per cycle while the result
// side does not stall, set by the single read and single write port of the
// tag store, with the row being written forwarded to a following access of
// the same set. Valid bits are flops cleared by reset, so no clearing pass is
// needed. Configuration writes take effect from the next access and must only
// be made while no access is in flight.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_controller #(
  parameter int SETS         = sacl_pkg::SETS_DEF,
  parameter int WAYS         = sacl_pkg::WAYS_DEF,
  parameter int BLOCK_BYTES  = sacl_pkg::BLOCK_BYTES_DEF,
  parameter int ADDRESS_BITS = sacl_pkg::ADDRESS_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sacl_in_if.sink    in_chan,
  sacl_out_if.source out_chan,
  sacl_cfg_if.sink   cfg_chan
);

  // geometry; non power-of-two sizes round down
  localparam int OFF_W   = sacl_pkg::floor_log2(BLOCK_BYTES);
  localparam int SET_W   = sacl_pkg::floor_log2(SETS);
  localparam int AB_EFF  = (ADDRESS_BITS < sacl_pkg::ADDR_W) ? ADDRESS_BITS : sacl_pkg::ADDR_W;
  localparam int TAG_RAW = AB_EFF - OFF_W - SET_W;
  localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int SIDX_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W   = TAG_W + 1 + WAY_W;
  localparam int AW      = sacl_pkg::ADDR_W;
  localparam logic [AW:0]   MASK_WIDE = (AW+1)'((AW+1)'(1) << AB_EFF) - (AW+1)'(1);
  localparam logic [AW-1:0] ADDR_MASK = MASK_WIDE[AW-1:0];
  localparam logic [AW-1:0] SET_MASK  = (AW'(1) << SET_W) - AW'(1);

  // --- configuration registers
  sacl_pkg::sacl_mode_t mode_r, mode_nxt;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        sacl_pkg::REG_WR_THRU:  mode_nxt.wr_thru  = cfg_chan.data[0];
        sacl_pkg::REG_WR_ALLOC: mode_nxt.wr_alloc = cfg_chan.data[0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '{wr_thru: 1'b0, wr_alloc: 1'b1};
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // --- lookup stage holds the access while its row sits in the read register
  logic                 b_v_r, b_v_nxt;
  sacl_pkg::sacl_req_t  b_req_r;
  logic                 out_v_r, out_v_nxt;
  sacl_pkg::sacl_res_t  out_r;
  logic                 in_acc, b_adv;

  assign b_adv           = b_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready   = !b_v_r || b_adv;
  assign in_acc          = in_chan.valid && in_chan.ready;

  assign b_v_nxt   = in_acc ? 1'b1 : (b_adv ? 1'b0 : b_v_r);
  assign out_v_nxt = b_adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      b_v_r   <= b_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // address split of the incoming access (store read) and the held one
  logic [AW-1:0]     in_addr_m, b_addr_m, in_set_full, b_set_full, b_tag_full;
  logic [SIDX_W-1:0] in_set, b_set;
  logic [TAG_W-1:0]  b_tag;

  assign in_addr_m   = in_chan.address & ADDR_MASK;
  assign in_set_full = (in_addr_m >> OFF_W) & SET_MASK;
  assign in_set      = in_set_full[SIDX_W-1:0];

  assign b_addr_m    = b_req_r.address;   // stored already masked
  assign b_set_full  = (b_addr_m >> OFF_W) & SET_MASK;
  assign b_set       = b_set_full[SIDX_W-1:0];
  assign b_tag_full  = b_addr_m >> (OFF_W + SET_W);
  assign b_tag       = b_tag_full[TAG_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_req_r <= '{operation: in_chan.operation, address: in_addr_m};
    end
  end

  // --- tag store and policy
  logic [WAYS-1:0][ENT_W-1:0] rd_row, wr_row;
  logic [WAYS-1:0]            rd_valid, wr_valid;
  sacl_pkg::sacl_res_t        res;

  sacl_tag_store #(
    .SETS   (SETS),
    .WAYS   (WAYS),
    .ENT_W  (ENT_W),
    .SIDX_W (SIDX_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_set   (in_set),
    .rd_row   (rd_row),
    .rd_valid (rd_valid),
    .wr_en    (b_adv),
    .wr_set   (b_set),
    .wr_row   (wr_row),
    .wr_valid (wr_valid)
  );

  sacl_policy #(
    .WAYS   (WAYS),
    .TAG_W  (TAG_W),
    .SIDX_W (SIDX_W),
    .OFF_W  (OFF_W),
    .SET_W  (SET_W)
  ) u_policy (
    .req     (b_req_r),
    .set_idx (b_set),
    .tag     (b_tag),
    .mode    (mode_r),
    .row     (rd_row),
    .vld     (rd_valid),
    .new_row (wr_row),
    .new_vld (wr_valid),
    .res     (res)
  );

  // --- result register; a stalled result keeps its payload
  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_r <= res;
    end
  end

  assign out_chan.valid             = out_v_r;
  assign out_chan.hit               = out_r.hit;
  assign out_chan.way               = out_r.way;
  assign out_chan.writeback_valid   = out_r.writeback_valid;
  assign out_chan.writeback_address = out_r.writeback_address;
  assign out_chan.lower_valid       = out_r.lower_valid;
  assign out_chan.lower_address     = out_r.lower_address;
  assign out_chan.lower_is_write    = out_r.lower_is_write;

endmodule

// ----- src/sacl_checker.sv -----
// ----------------------------------------------------------------------------
// sacl_port_checks: port-level checks of the cache tag and policy engine
// Result channel behaviour and consistency of the result fields.
// ----------------------------------------------------------------------------
module sacl_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [1:0]  way,
  input logic        writeback_valid,
  input logic [31:0] writeback_address,
  input logic        lower_valid,
  input logic [31:0] lower_address,
  input logic        lower_is_write
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(hit) && $stable(way) &&
      $stable(writeback_valid) && $stable(writeback_address) &&
      $stable(lower_valid) && $stable(lower_address) && $stable(lower_is_write))
    else $error("stalled result changed");

  // a writeback only comes from a miss that fills a line
  a_wb_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && writeback_valid |-> !hit && lower_valid && !lower_is_write)
    else $error("writeback without fill");

  // nothing sent below: lower fields and writeback clear
  a_no_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !lower_valid |-> (lower_address == 32'd0) && !lower_is_write &&
      !writeback_valid && (writeback_address == 32'd0))
    else $error("stray lower request fields");

  // a hit only ever forwards a write
  a_hit_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit && lower_valid |-> lower_is_write && !writeback_valid)
    else $error("hit issued a fill");

endmodule

bind set_assoc_cache_lru_controller sacl_port_checks u_port_checks (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .hit               (out_chan.hit),
  .way               (out_chan.way),
  .writeback_valid   (out_chan.writeback_valid),
  .writeback_address (out_chan.writeback_address),
  .lower_valid       (out_chan.lower_valid),
  .lower_address     (out_chan.lower_address),
  .lower_is_write    (out_chan.lower_is_write)
);

// ----- dv/sacl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_checker: result checker of the cache tag and policy engine
// Watches the access, result and register channels, keeps its own copy of
// tags, dirty bits, valid bits and LRU ages, and compares every result.
// ----------------------------------------------------------------------------
module sacl_checker
  import sacl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sacl_in_if          in_mon,
  sacl_out_if         out_mon,
  sacl_cfg_if         cfg_mon,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned results_seen,
  output int unsigned hits_seen,
  output int unsigned writebacks_seen,
  output int unsigned forwards_seen
);

  localparam int OFF_W = $clog2(BLOCK_BYTES_DEF);
  localparam int SET_W = $clog2(SETS_DEF);
  localparam int WAY_W = $clog2(WAYS_DEF);
  localparam int TAG_W = ADDR_W - SET_W - OFF_W;
  localparam int LINES = SETS_DEF * WAYS_DEF;

  logic             line_ok    [LINES];
  logic             line_dirty [LINES];
  logic [TAG_W-1:0] line_tag   [LINES];
  logic [WAY_W-1:0] line_age   [LINES];
  sacl_mode_t       policy;
  sacl_res_t        expected_results [$];

  int unsigned fail_cnt = 0;
  int unsigned res_cnt  = 0;
  int unsigned hit_cnt  = 0;
  int unsigned wb_cnt   = 0;
  int unsigned fwd_cnt  = 0;

  // make way_no the youngest; only lines younger than prior grow older
  function automatic void make_youngest(input int base, input int way_no, input int prior);
    for (int i = 0; i < WAYS_DEF; i++)
      if (i != way_no && line_ok[base+i] && int'(line_age[base+i]) < prior &&
          int'(line_age[base+i]) < WAYS_DEF - 1)
        line_age[base+i] = line_age[base+i] + 1'b1;
    line_age[base+way_no] = '0;
  endfunction

  function automatic sacl_res_t lookup_and_update(input logic is_write,
                                                  input logic [ADDR_W-1:0] addr);
    sacl_res_t        res;
    logic [SET_W-1:0] set_no;
    logic [TAG_W-1:0] tag_no;
    int               base;
    int               hit_way;
    int               victim;
    int               oldest;
    int               prior;
    set_no  = addr[OFF_W +: SET_W];
    tag_no  = addr[ADDR_W-1 -: TAG_W];
    base    = int'(set_no) * WAYS_DEF;
    res     = '0;
    hit_way = -1;
    for (int i = 0; i < WAYS_DEF; i++)
      if (line_ok[base+i] && line_tag[base+i] == tag_no) hit_way = i;

    if (hit_way >= 0) begin
      res.hit = 1'b1;
      res.way = hit_way[WAY_W-1:0];
      make_youngest(base, hit_way, int'(line_age[base+hit_way]));
      if (is_write) begin
        if (policy.wr_thru) begin
          res.lower_valid    = 1'b1;
          res.lower_address  = addr;
          res.lower_is_write = 1'b1;
        end else begin
          line_dirty[base+hit_way] = 1'b1;
        end
      end
    end else if (is_write && !policy.wr_alloc) begin
      res.lower_valid    = 1'b1;
      res.lower_address  = addr;
      res.lower_is_write = 1'b1;
    end else begin
      // lowest empty way first, else the oldest line
      victim = -1;
      for (int i = 0; i < WAYS_DEF; i++)
        if (victim < 0 && !line_ok[base+i]) victim = i;
      if (victim < 0) begin
        oldest = 0;
        victim = 0;
        for (int i = 0; i < WAYS_DEF; i++)
          if (int'(line_age[base+i]) > oldest) begin
            oldest = int'(line_age[base+i]);
            victim = i;
          end
      end
      if (line_ok[base+victim] && line_dirty[base+victim]) begin
        res.writeback_valid   = 1'b1;
        res.writeback_address = {line_tag[base+victim], set_no, {OFF_W{1'b0}}};
      end
      res.lower_valid   = 1'b1;
      res.lower_address = {addr[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
      prior = line_ok[base+victim] ? int'(line_age[base+victim]) : WAYS_DEF;
      line_ok[base+victim]    = 1'b1;
      line_tag[base+victim]   = tag_no;
      line_dirty[base+victim] = is_write;
      make_youngest(base, victim, prior);
      res.way = victim[WAY_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    sacl_res_t got;
    sacl_res_t want;
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        line_ok[i]    = 1'b0;
        line_dirty[i] = 1'b0;
        line_tag[i]   = '0;
        line_age[i]   = '0;
      end
      policy.wr_thru  = 1'b0;
      policy.wr_alloc = 1'b1;
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_WR_THRU:  policy.wr_thru  = cfg_mon.data[0];
          REG_WR_ALLOC: policy.wr_alloc = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.hit               = out_mon.hit;
        got.way               = out_mon.way;
        got.writeback_valid   = out_mon.writeback_valid;
        got.writeback_address = out_mon.writeback_address;
        got.lower_valid       = out_mon.lower_valid;
        got.lower_address     = out_mon.lower_address;
        got.lower_is_write    = out_mon.lower_is_write;
        res_cnt++;
        if (got.hit === 1'b1) hit_cnt++;
        if (got.writeback_valid === 1'b1) wb_cnt++;
        if (got.lower_valid === 1'b1 && got.lower_is_write === 1'b1) fwd_cnt++;
        if (expected_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: result %0d with nothing outstanding: hit %b way %0d", $time,
                     res_cnt, got.hit, got.way);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"%0t: result %0d exp hit %b way %0d wb %b %h low %b %h %b",
                        " / got hit %b way %0d wb %b %h low %b %h %b"}, $time, res_cnt,
                       want.hit, want.way, want.writeback_valid, want.writeback_address,
                       want.lower_valid, want.lower_address, want.lower_is_write,
                       got.hit, got.way, got.writeback_valid, got.writeback_address,
                       got.lower_valid, got.lower_address, got.lower_is_write);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(lookup_and_update(in_mon.operation, in_mon.address));
    end
    mismatches      <= fail_cnt;
    outstanding     <= expected_results.size();
    results_seen    <= res_cnt;
    hits_seen       <= hit_cnt;
    writebacks_seen <= wb_cnt;
    forwards_seen   <= fwd_cnt;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the set-associative cache tag and policy engine
// Drives accesses and register writes, idles both channel ends at random and
// leaves the result checking to sacl_checker; prints the verdict at the end.
// ----------------------------------------------------------------------------
module tb;
  import sacl_pkg::*;

  localparam int OFF_W = $clog2(BLOCK_BYTES_DEF);
  localparam int SET_W = $clog2(SETS_DEF);
  localparam int TAG_W = ADDR_W - SET_W - OFF_W;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // an index outside the register map; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;

  // small pools of tags and sets so that lines are reused, aged and evicted
  localparam int TAG_POOL = 6;
  localparam int SET_POOL = 4;

  localparam int HOLD_CYCLES = 400;  // long result-side hold-off
  localparam int NO_EVENT    = -1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sacl_in_if  in_chan ();
  sacl_out_if out_chan ();
  sacl_cfg_if cfg_chan ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned writebacks_seen;
  int unsigned forwards_seen;

  int unsigned accesses_sent = 0;
  int unsigned hold_asks     = 0;  // bumped by stimulus, followed by the sink

  logic [TAG_W-1:0] tag_pool [TAG_POOL];
  logic [SET_W-1:0] set_pool [SET_POOL];

  always #5 clk = ~clk;

  set_assoc_cache_lru_controller dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  sacl_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_mon         (cfg_chan),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_seen    (results_seen),
    .hits_seen       (hits_seen),
    .writebacks_seen (writebacks_seen),
    .forwards_seen   (forwards_seen)
  );

  // Safety net: several times what the slowest legal run needs.
  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pause_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Mostly pooled tag/set pairs with a random offset; a few fully random.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [OFF_W-1:0] offset;
    offset = OFF_W'($urandom);
    if ($urandom_range(99) < 8) return $urandom;
    return {tag_pool[$urandom_range(TAG_POOL-1)], set_pool[$urandom_range(SET_POOL-1)],
            offset};
  endfunction

  // --------------------------------------------------------------------------
  // Result sink. A long hold is counted here; otherwise random stalls with
  // calm stretches of constant ready in between.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned r;
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    calm_left  = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        out_chan.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 2) begin
          calm_left = $urandom_range(150, 40);
          out_chan.ready <= 1'b1;
        end else if (r >= 75) begin
          stall_left = pause_length() - 1;
          out_chan.ready <= 1'b0;
        end else begin
          out_chan.ready <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Valid is never lowered and raised in one time step:
  // the access task leaves it high, only gaps and drains drop it.
  // --------------------------------------------------------------------------
  task automatic access(input logic op, input logic [ADDR_W-1:0] addr);
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.address   <= addr;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    accesses_sent++;
  endtask

  task automatic idle_in(input int unsigned cycles);
    if (cycles != 0) begin
      in_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result. The first edge lets
  // the checker's count take in the last transfer.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Leaves cfg valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic bit0);
    logic [CFG_DATA_W-1:0] word;
    word    = $urandom;  // upper bits are don't-care
    word[0] = bit0;
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= word;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
  endtask

  // Mode change only with the engine idle.
  task automatic set_modes(input logic wt, input logic wa, input logic stray);
    drain();
    if (stray) write_reg(REG_UNMAPPED, 1'($urandom_range(1)));
    write_reg(REG_WR_THRU, wt);
    write_reg(REG_WR_ALLOC, wa);
    cfg_chan.valid <= 1'b0;
  endtask

  // One random phase under fixed modes. hold_at starts the long result hold
  // with a back-to-back burst behind it; drain_at pauses until all is back.
  task automatic run_phase(input logic wt, input logic wa, input logic stray,
                           input int count, input int hold_at, input int drain_at);
    int unsigned burst_left;
    set_modes(wt, wa, stray);
    for (int i = 0; i < TAG_POOL; i++) tag_pool[i] = TAG_W'($urandom);
    for (int i = 0; i < SET_POOL; i++) set_pool[i] = SET_W'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    set_pool[0] = '0;
    set_pool[1] = '1;
    burst_left  = 0;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) begin
        hold_asks  <= hold_asks + 1;
        burst_left  = 60;
      end
      if (n == drain_at) drain();
      if ($urandom_range(199) == 0)
        tag_pool[$urandom_range(TAG_POOL-1)] = TAG_W'($urandom);
      if (burst_left != 0) begin
        burst_left--;
      end else if ($urandom_range(49) == 0) begin
        burst_left = $urandom_range(80, 20);
      end else if ($urandom_range(99) >= 55) begin
        idle_in(pause_length());
      end
      access(1'($urandom_range(1)), pick_address());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_READ;
    in_chan.address   = '0;
    cfg_chan.valid    = 1'b0;
    cfg_chan.index    = REG_WR_THRU;
    cfg_chan.data     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // write-back, write-allocate: fill set 0, hit, dirty, evict a dirty line
    set_modes(1'b0, 1'b1, 1'b0);
    access(OP_READ,  32'h0000_0000);  // cold miss, way 0
    access(OP_READ,  32'h0000_003F);  // same block, top offset: hit
    access(OP_WRITE, 32'h0000_0004);  // write hit marks dirty
    access(OP_READ,  32'h0000_1000);
    access(OP_READ,  32'h0000_2010);
    access(OP_WRITE, 32'h0000_3020);  // write miss allocates, dirty
    access(OP_READ,  32'h0000_1008);  // hit reorders ages
    access(OP_READ,  32'h0000_4000);  // set full: dirty LRU line written back
    access(OP_READ,  32'h0000_5000);  // clean eviction
    access(OP_READ,  32'hFFFF_FFFF);  // top set, all-ones tag
    access(OP_WRITE, 32'hFFFF_FFC0);
    access(OP_WRITE, 32'h0000_0FC0);  // top set, zero tag
    access(OP_READ,  32'hAAAA_A555);
    access(OP_WRITE, 32'h5555_5AAA);

    // write-through with allocate: forwarded write hit, allocating write miss
    set_modes(1'b1, 1'b1, 1'b0);
    access(OP_WRITE, 32'h0000_4004);
    access(OP_WRITE, 32'h0000_6000);  // fills and marks dirty, nothing forwarded
    access(OP_READ,  32'h0000_6000);
    access(OP_READ,  32'h0000_7000);

    // write-back without allocate: write misses only go to lower memory
    set_modes(1'b0, 1'b0, 1'b0);
    access(OP_WRITE, 32'h0000_8000);
    access(OP_READ,  32'h0000_8000);
    access(OP_WRITE, 32'h0000_8008);
    access(OP_WRITE, 32'hFFFF_FFFC);
    access(OP_WRITE, 32'h1234_5678);

    // random phases through every mode pairing
    run_phase(1'b0, 1'b1, 1'b0, 200, 50,       NO_EVENT);
    run_phase(1'b1, 1'b1, 1'b1, 200, NO_EVENT, NO_EVENT);
    run_phase(1'b0, 1'b0, 1'b0, 200, NO_EVENT, 100);
    run_phase(1'b1, 1'b0, 1'b0, 200, NO_EVENT, NO_EVENT);
    run_phase(1'b0, 1'b1, 1'b1, 200, 120,      150);

    drain();
    repeat (20) @(posedge clk);  // catch any stray trailing result

    $display("Sent %0d accesses, checked %0d results: %0d hits, %0d writebacks, %0d %s",
             accesses_sent, results_seen, hits_seen, writebacks_seen, forwards_seen,
             "forwarded writes");
    $display("Covered all four write-through/allocate pairings and two long result holds.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
